/* src/rgbpfc_pkg.sv */
package rgbpfc_pkg;

  localparam int PIXEL_W = 32;
  localparam int COMP_W  = 16;
  localparam int WIDTH_W = 4;
  localparam int POS_W   = 5;
  localparam int IDX_W   = 3;
  localparam int MAX_BITS = 8;

  // pixel format codes
  localparam logic [1:0] FMT_16_NATIVE = 2'd0;
  localparam logic [1:0] FMT_16_SWAP   = 2'd1;
  localparam logic [1:0] FMT_32_NATIVE = 2'd2;
  localparam logic [1:0] FMT_32_SWAP   = 2'd3;

  // request kinds
  localparam logic KIND_UNPACK = 1'b0;
  localparam logic KIND_PACK   = 1'b1;

  // register indexes
  localparam logic [IDX_W-1:0] REG_PIXEL_FORMAT   = 3'd0;
  localparam logic [IDX_W-1:0] REG_FLIP_MASK      = 3'd1;
  localparam logic [IDX_W-1:0] REG_RED_WIDTH      = 3'd2;
  localparam logic [IDX_W-1:0] REG_RED_POSITION   = 3'd3;
  localparam logic [IDX_W-1:0] REG_GREEN_WIDTH    = 3'd4;
  localparam logic [IDX_W-1:0] REG_GREEN_POSITION = 3'd5;
  localparam logic [IDX_W-1:0] REG_BLUE_WIDTH     = 3'd6;
  localparam logic [IDX_W-1:0] REG_BLUE_POSITION  = 3'd7;

  typedef struct packed {
    logic                kind;
    logic [PIXEL_W-1:0]  pixel_in;
    logic [COMP_W-1:0]   red_in;
    logic [COMP_W-1:0]   green_in;
    logic [COMP_W-1:0]   blue_in;
  } in_t;

  typedef struct packed {
    logic [PIXEL_W-1:0]  pixel_out;
    logic [COMP_W-1:0]   red_out;
    logic [COMP_W-1:0]   green_out;
    logic [COMP_W-1:0]   blue_out;
  } out_t;

  typedef struct packed {
    logic [WIDTH_W-1:0] width;
    logic [POS_W-1:0]   position;
  } lane_cfg_t;

  typedef struct packed {
    logic [1:0]         pixel_format;
    logic [PIXEL_W-1:0] flip_mask;
  } merge_cfg_t;

  function automatic logic is32(input logic [1:0] fmt);
    return fmt inside {FMT_32_NATIVE, FMT_32_SWAP};
  endfunction

  function automatic logic is_swapped(input logic [1:0] fmt);
    return fmt inside {FMT_16_SWAP, FMT_32_SWAP};
  endfunction

  function automatic logic [PIXEL_W-1:0] swap_pixel(input logic [1:0] fmt,
                                                    input logic [PIXEL_W-1:0] v);
    logic [PIXEL_W-1:0] r;
    case (fmt)
      FMT_16_SWAP: r = {16'h0000, v[7:0], v[15:8]};
      FMT_32_SWAP: r = {v[7:0], v[15:8], v[23:16], v[31:24]};
      default:     r = v;
    endcase
    return r;
  endfunction

  // fill 16 bits by repeating the n kept bits from the top down
  function automatic logic [COMP_W-1:0] replicate(input logic [WIDTH_W-1:0] n,
                                                  input logic [MAX_BITS-1:0] b);
    logic [COMP_W-1:0] r;
    case (n)
      4'd1:    r = {16{b[0]}};
      4'd2:    r = {8{b[1:0]}};
      4'd3:    r = {{5{b[2:0]}}, b[2]};
      4'd4:    r = {4{b[3:0]}};
      4'd5:    r = {{3{b[4:0]}}, b[4]};
      4'd6:    r = {{2{b[5:0]}}, b[5:2]};
      4'd7:    r = {{2{b[6:0]}}, b[6:5]};
      4'd8:    r = {2{b[7:0]}};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* src/rgbpfc_lane.sv */
module rgbpfc_lane (
  input  logic                                clk,
  input  rgbpfc_pkg::lane_cfg_t               cfg,
  input  logic [rgbpfc_pkg::PIXEL_W-1:0]      pixel,
  input  logic [rgbpfc_pkg::COMP_W-1:0]       comp,
  output logic [rgbpfc_pkg::COMP_W-1:0]       unpack_r,
  output logic [rgbpfc_pkg::PIXEL_W-1:0]      pack_r
);

  logic [rgbpfc_pkg::WIDTH_W-1:0]  n;
  logic [rgbpfc_pkg::MAX_BITS-1:0] field_mask;
  logic [rgbpfc_pkg::MAX_BITS-1:0] bits;
  logic [rgbpfc_pkg::MAX_BITS-1:0] hb;
  logic [rgbpfc_pkg::COMP_W-1:0]   unpack_nxt;
  logic [rgbpfc_pkg::PIXEL_W-1:0]  pack_nxt;

  always_comb begin
    n = (cfg.width > 4'd8) ? 4'd8 : cfg.width;
    field_mask = 8'((9'd1 << n) - 9'd1);
    bits = 8'(pixel >> cfg.position) & field_mask;
    unpack_nxt = rgbpfc_pkg::replicate(n, bits);
    // top n bits of the high byte
    hb = comp[15:8] >> (4'd8 - n);
    if (n == 4'd0) begin
      pack_nxt = '0;
    end else begin
      pack_nxt = {24'h000000, hb} << cfg.position;
    end
  end

  always_ff @(posedge clk) begin
    unpack_r <= unpack_nxt;
    pack_r   <= pack_nxt;
  end

endmodule

/* src/rgbpfc_merge.sv */
module rgbpfc_merge (
  input  logic                            clk,
  input  rgbpfc_pkg::merge_cfg_t          cfg,
  input  logic                            kind,
  input  logic [rgbpfc_pkg::COMP_W-1:0]   red_unpack,
  input  logic [rgbpfc_pkg::COMP_W-1:0]   green_unpack,
  input  logic [rgbpfc_pkg::COMP_W-1:0]   blue_unpack,
  input  logic [rgbpfc_pkg::PIXEL_W-1:0]  red_pack,
  input  logic [rgbpfc_pkg::PIXEL_W-1:0]  green_pack,
  input  logic [rgbpfc_pkg::PIXEL_W-1:0]  blue_pack,
  output rgbpfc_pkg::out_t                item_r
);

  logic [rgbpfc_pkg::PIXEL_W-1:0] mask;
  logic [rgbpfc_pkg::PIXEL_W-1:0] merged;
  rgbpfc_pkg::out_t               item_nxt;

  always_comb begin
    mask = rgbpfc_pkg::is32(cfg.pixel_format) ? cfg.flip_mask
                                              : {cfg.flip_mask[15:0], cfg.flip_mask[15:0]};
    merged = (red_pack | green_pack | blue_pack) ^ mask;
    item_nxt = '0;
    if (kind == rgbpfc_pkg::KIND_PACK) begin
      item_nxt.pixel_out = rgbpfc_pkg::swap_pixel(cfg.pixel_format, merged);
    end else begin
      item_nxt.red_out   = red_unpack;
      item_nxt.green_out = green_unpack;
      item_nxt.blue_out  = blue_unpack;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

endmodule

/* src/rgb_pixel_format_converter_core.sv */
// Converts one request per clock between a packed pixel and three 16-bit
// components, with kind selecting unpack or pack. The block is never busy: a
// request taken with start is held in the first and the second stage registers
// in turn and appears on out_item, marked by out_valid for exactly one cycle,
// one lane per component in the first stage and the merge of the lanes (or,
// xor mask, byte swap) in the second. The receiver cannot stall, so results
// must be taken when shown. Configuration writes are always ready and take
// effect on the next request; change them only when no request is in flight.
module rgb_pixel_format_converter_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  rgbpfc_pkg::in_t                 in_item,
  output logic                            out_valid,
  output rgbpfc_pkg::out_t                out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rgbpfc_pkg::IDX_W-1:0]    cfg_index,
  input  logic [rgbpfc_pkg::PIXEL_W-1:0]  cfg_data
);

  logic [1:0]                      pixel_format_r;
  logic [rgbpfc_pkg::PIXEL_W-1:0]  flip_mask_r;
  rgbpfc_pkg::lane_cfg_t           red_cfg_r;
  rgbpfc_pkg::lane_cfg_t           green_cfg_r;
  rgbpfc_pkg::lane_cfg_t           blue_cfg_r;

  logic                            stage1_valid_r;
  logic                            out_valid_r;
  logic                            kind_r;
  logic [rgbpfc_pkg::PIXEL_W-1:0]  pixel_sw;
  logic [rgbpfc_pkg::COMP_W-1:0]   red_unpack;
  logic [rgbpfc_pkg::COMP_W-1:0]   green_unpack;
  logic [rgbpfc_pkg::COMP_W-1:0]   blue_unpack;
  logic [rgbpfc_pkg::PIXEL_W-1:0]  red_pack;
  logic [rgbpfc_pkg::PIXEL_W-1:0]  green_pack;
  logic [rgbpfc_pkg::PIXEL_W-1:0]  blue_pack;
  rgbpfc_pkg::merge_cfg_t          merge_cfg;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_format_r       <= rgbpfc_pkg::FMT_32_NATIVE;
      flip_mask_r          <= '0;
      red_cfg_r.width      <= 4'd8;
      red_cfg_r.position   <= 5'd16;
      green_cfg_r.width    <= 4'd8;
      green_cfg_r.position <= 5'd8;
      blue_cfg_r.width     <= 4'd8;
      blue_cfg_r.position  <= 5'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rgbpfc_pkg::REG_PIXEL_FORMAT:   pixel_format_r       <= cfg_data[1:0];
        rgbpfc_pkg::REG_FLIP_MASK:      flip_mask_r          <= cfg_data;
        rgbpfc_pkg::REG_RED_WIDTH:      red_cfg_r.width      <= cfg_data[3:0];
        rgbpfc_pkg::REG_RED_POSITION:   red_cfg_r.position   <= cfg_data[4:0];
        rgbpfc_pkg::REG_GREEN_WIDTH:    green_cfg_r.width    <= cfg_data[3:0];
        rgbpfc_pkg::REG_GREEN_POSITION: green_cfg_r.position <= cfg_data[4:0];
        rgbpfc_pkg::REG_BLUE_WIDTH:     blue_cfg_r.width     <= cfg_data[3:0];
        rgbpfc_pkg::REG_BLUE_POSITION:  blue_cfg_r.position  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage1_valid_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      stage1_valid_r <= start && !busy;
      out_valid_r    <= stage1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= in_item.kind;
  end

  // unpack sees the pixel in native byte order
  assign pixel_sw = rgbpfc_pkg::swap_pixel(pixel_format_r, in_item.pixel_in);

  rgbpfc_lane u_lane_red (
    .clk      (clk),
    .cfg      (red_cfg_r),
    .pixel    (pixel_sw),
    .comp     (in_item.red_in),
    .unpack_r (red_unpack),
    .pack_r   (red_pack)
  );

  rgbpfc_lane u_lane_green (
    .clk      (clk),
    .cfg      (green_cfg_r),
    .pixel    (pixel_sw),
    .comp     (in_item.green_in),
    .unpack_r (green_unpack),
    .pack_r   (green_pack)
  );

  rgbpfc_lane u_lane_blue (
    .clk      (clk),
    .cfg      (blue_cfg_r),
    .pixel    (pixel_sw),
    .comp     (in_item.blue_in),
    .unpack_r (blue_unpack),
    .pack_r   (blue_pack)
  );

  always_comb begin
    merge_cfg.pixel_format = pixel_format_r;
    merge_cfg.flip_mask    = flip_mask_r;
  end

  rgbpfc_merge u_merge (
    .clk          (clk),
    .cfg          (merge_cfg),
    .kind         (kind_r),
    .red_unpack   (red_unpack),
    .green_unpack (green_unpack),
    .blue_unpack  (blue_unpack),
    .red_pack     (red_pack),
    .green_pack   (green_pack),
    .blue_pack    (blue_pack),
    .item_r       (out_item)
  );

`ifndef ASSERT_OFF
  a_stage1_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (stage1_valid_r == $past(start && !busy)))
    else $error("stage 1 valid does not follow accepted request");

  a_out_follows_stage1: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (out_valid_r == $past(stage1_valid_r)))
    else $error("result strobe does not follow stage 1");

  a_unpack_pixel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && out_valid_r && ($past(kind_r) == rgbpfc_pkg::KIND_UNPACK))
      |-> (out_item.pixel_out == '0))
    else $error("unpack result carries a nonzero pixel");
`endif

endmodule

/* test/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rgbpfc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES = 16;
  localparam int PHASE_REQUESTS = 100;

  // expected-result store plus a predictor of the converter
  class conversion_tracker;
    logic [1:0]         fmt;
    logic [PIXEL_W-1:0] mask;
    logic [WIDTH_W-1:0] lane_width [3];
    logic [POS_W-1:0]   lane_pos [3];
    out_t               pending_conversions [$];
    int                 failures;

    function new();
      fmt = FMT_32_NATIVE;
      mask = '0;
      lane_width = '{4'd8, 4'd8, 4'd8};
      lane_pos = '{5'd16, 5'd8, 5'd0};
      failures = 0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [PIXEL_W-1:0] d);
      case (idx)
        REG_PIXEL_FORMAT:   fmt = d[1:0];
        REG_FLIP_MASK:      mask = d;
        REG_RED_WIDTH:      lane_width[0] = d[WIDTH_W-1:0];
        REG_RED_POSITION:   lane_pos[0] = d[POS_W-1:0];
        REG_GREEN_WIDTH:    lane_width[1] = d[WIDTH_W-1:0];
        REG_GREEN_POSITION: lane_pos[1] = d[POS_W-1:0];
        REG_BLUE_WIDTH:     lane_width[2] = d[WIDTH_W-1:0];
        REG_BLUE_POSITION:  lane_pos[2] = d[POS_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [PIXEL_W-1:0] byte_order(logic [PIXEL_W-1:0] v);
      case (fmt)
        FMT_16_SWAP: return {16'h0000, v[7:0], v[15:8]};
        FMT_32_SWAP: return {v[7:0], v[15:8], v[23:16], v[31:24]};
        default:     return v;
      endcase
    endfunction

    // widths above eight behave as eight, zero width gives nothing
    function int bits_used(logic [WIDTH_W-1:0] w);
      return (w > 8) ? 8 : int'(w);
    endfunction

    function logic [COMP_W-1:0] unpack_lane(logic [PIXEL_W-1:0] pix, int lane);
      int                n;
      logic [7:0]        grab;
      logic [COMP_W-1:0] top;
      logic [COMP_W-1:0] v;
      n = bits_used(lane_width[lane]);
      if (n == 0) return '0;
      grab = 8'(pix >> lane_pos[lane]) & 8'((1 << n) - 1);
      top = 16'(grab) << (16 - n);
      v = top;
      for (int s = n; s < 16; s += n) v |= top >> s;
      return v;
    endfunction

    function logic [PIXEL_W-1:0] pack_lane(logic [COMP_W-1:0] comp, int lane);
      int          n;
      logic [63:0] hb;
      n = bits_used(lane_width[lane]);
      if (n == 0) return '0;
      hb = 64'(comp[15:8]) >> (8 - n);
      return 32'(hb << lane_pos[lane]);
    endfunction

    function out_t convert(in_t req);
      out_t               r;
      logic [PIXEL_W-1:0] pix;
      logic [PIXEL_W-1:0] m;
      r = '0;
      if (req.kind == KIND_UNPACK) begin
        pix = byte_order(req.pixel_in);
        r.red_out = unpack_lane(pix, 0);
        r.green_out = unpack_lane(pix, 1);
        r.blue_out = unpack_lane(pix, 2);
      end else begin
        m = (fmt inside {FMT_32_NATIVE, FMT_32_SWAP}) ? mask
                                                      : {mask[15:0], mask[15:0]};
        pix = pack_lane(req.red_in, 0) | pack_lane(req.green_in, 1) |
              pack_lane(req.blue_in, 2);
        r.pixel_out = byte_order(pix ^ m);
      end
      return r;
    endfunction

    function void note_request(in_t req);
      pending_conversions.push_back(convert(req));
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending_conversions.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: pixel %h red %h green %h blue %h",
                   got.pixel_out, got.red_out, got.green_out, got.blue_out);
        return;
      end
      want = pending_conversions.pop_front();
      if (got.pixel_out !== want.pixel_out || got.red_out !== want.red_out ||
          got.green_out !== want.green_out || got.blue_out !== want.blue_out) begin
        failures++;
        if (failures <= 10)
          $display("mismatch: pixel %h/%h red %h/%h green %h/%h blue %h/%h (exp/got)",
                   want.pixel_out, got.pixel_out, want.red_out, got.red_out,
                   want.green_out, got.green_out, want.blue_out, got.blue_out);
      end
    endfunction

    function int pending();
      return pending_conversions.size();
    endfunction
  endclass

  logic               clk;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  in_t                in_item = '0;
  logic               out_valid;
  out_t               out_item;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [IDX_W-1:0]   cfg_index = REG_PIXEL_FORMAT;
  logic [PIXEL_W-1:0] cfg_data = '0;
  int                 cycles = 0;

  conversion_tracker tracker = new();

  rgb_pixel_format_converter_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // outputs are stable at the falling edge, so sample there
  always @(negedge clk) begin
    if (rst_n && out_valid) tracker.check_result(out_item);
  end

  // entered just after a rising edge; leaves start high for a following request
  task automatic push_request(input in_t req);
    start <= 1'b1;
    in_item <= req;
    do @(negedge clk); while (busy);
    tracker.note_request(req);
    @(posedge clk);
  endtask

  task automatic pause(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [PIXEL_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(negedge clk); while (!cfg_ready);
    tracker.set_reg(idx, d);
    @(posedge clk);
  endtask

  task automatic set_all(input logic [31:0] fmt, input logic [31:0] mask,
                         input logic [31:0] rw, input logic [31:0] rp,
                         input logic [31:0] gw, input logic [31:0] gp,
                         input logic [31:0] bw, input logic [31:0] bp);
    write_reg(REG_PIXEL_FORMAT, fmt);
    write_reg(REG_FLIP_MASK, mask);
    write_reg(REG_RED_WIDTH, rw);
    write_reg(REG_RED_POSITION, rp);
    write_reg(REG_GREEN_WIDTH, gw);
    write_reg(REG_GREEN_POSITION, gp);
    write_reg(REG_BLUE_WIDTH, bw);
    write_reg(REG_BLUE_POSITION, bp);
    cfg_valid <= 1'b0;
  endtask

  // extreme settings: 16bpp with two lanes in the high half, single-bit lanes,
  // zero and oversized widths, every pixel format
  task automatic corner_config(input int which);
    case (which)
      0: set_all(32'(FMT_16_NATIVE), 32'hFFFF_FFFF, 8, 31, 8, 24, 8, 0);
      1: set_all(32'(FMT_16_SWAP), 32'hA5A5_5A5A, 1, 0, 1, 15, 1, 31);
      2: set_all(32'(FMT_32_SWAP), 32'h0000_0000, 0, 31, 15, 28, 4, 12);
      default: set_all(32'(FMT_32_NATIVE), 32'hFFFF_FFFF, 15, 24, 9, 16, 8, 8);
    endcase
  endtask

  function automatic logic [31:0] random_width();
    logic [3:0] w;
    if ($urandom_range(9) == 0) w = ($urandom_range(1) == 0) ? 4'd0 : 4'($urandom_range(9, 15));
    else w = 4'($urandom_range(1, 8));
    return {28'($urandom), w};
  endfunction

  function automatic logic [31:0] random_mask();
    case ($urandom_range(3))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_config();
    set_all($urandom, random_mask(), random_width(), $urandom,
            random_width(), $urandom, random_width(), $urandom);
  endtask

  function automatic in_t make_request(input logic kind, input logic [31:0] pix,
                                       input logic [15:0] r, input logic [15:0] g,
                                       input logic [15:0] b);
    in_t req;
    req.kind = kind;
    req.pixel_in = pix;
    req.red_in = r;
    req.green_in = g;
    req.blue_in = b;
    return req;
  endfunction

  function automatic in_t random_request();
    logic [31:0] pix;
    case ($urandom_range(15))
      0: pix = 32'h0000_0000;
      1: pix = 32'hFFFF_FFFF;
      default: pix = $urandom;
    endcase
    return make_request($urandom_range(1) ? KIND_PACK : KIND_UNPACK, pix,
                        16'($urandom), 16'($urandom), 16'($urandom));
  endfunction

  task automatic directed_requests();
    push_request(make_request(KIND_UNPACK, 32'h0000_0000, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    push_request(make_request(KIND_UNPACK, 32'hFFFF_FFFF, 16'h0000, 16'h0000, 16'h0000));
    push_request(make_request(KIND_UNPACK, 32'h80C3_5A01, 16'h1234, 16'h5678, 16'h9ABC));
    push_request(make_request(KIND_PACK, 32'hFFFF_FFFF, 16'h0000, 16'h0000, 16'h0000));
    push_request(make_request(KIND_PACK, 32'h0000_0000, 16'hFFFF, 16'h8000, 16'h7F00));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values first, then each extreme setting
    directed_requests();
    for (int c = 0; c < 4; c++) begin
      settle();
      corner_config(c);
      directed_requests();
    end

    for (int p = 0; p < PHASES; p++) begin
      settle();
      if (p < 4) corner_config(p);
      else random_config();
      for (int k = 0; k < PHASE_REQUESTS; k++) begin
        // phases 6 to 8 run back to back with no gaps
        if ((p < 6 || p > 8) && $urandom_range(99) < 6) pause(1);
        push_request(random_request());
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (tracker.pending() != 0) begin
      tracker.failures++;
      $display("%0d expected results never arrived", tracker.pending());
    end
    if (tracker.failures == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* filelist.f */
src/rgbpfc_pkg.sv
src/rgbpfc_lane.sv
src/rgbpfc_merge.sv
src/rgb_pixel_format_converter_core.sv
test/testbench.sv
